/* src/htbs_pkg.sv */
`default_nettype none
package htbs_pkg;

    localparam int MAX_TEXTURES_DEF = 4;
    localparam int TEXEL_W = 24;
    localparam int REG_IDX_W = 3;
    localparam int PADDR_W = 5;

    localparam logic [REG_IDX_W-1:0] REG_MAX_HEIGHT     = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_TEXTURE_COUNT  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_SLOPE_LIGHTING = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_MIN_BRIGHTNESS = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_MAX_BRIGHTNESS = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_SOFTNESS       = 3'd5;

    localparam logic [9:0]  RST_MAX_HEIGHT     = 10'd255;
    localparam logic [2:0]  RST_TEXTURE_COUNT  = 3'd4;
    localparam logic        RST_SLOPE_LIGHTING = 1'b1;
    localparam logic [9:0]  RST_MIN_BRIGHTNESS = 10'd128;
    localparam logic [9:0]  RST_MAX_BRIGHTNESS = 10'd256;
    localparam logic [15:0] RST_SOFTNESS       = 16'd256;

    localparam int BAND_MARGIN   = 5;
    localparam int HEIGHT_OFFSET = 50;
    localparam int SHADE_ONE     = 256;
    localparam int CHAN_MAX      = 255;

    typedef struct packed {
        logic [7:0]         height;
        logic [TEXEL_W-1:0] texel_0;
        logic [TEXEL_W-1:0] texel_1;
        logic [TEXEL_W-1:0] texel_2;
        logic [TEXEL_W-1:0] texel_3;
        logic [7:0]         neighbour_height;
        logic               neighbour_inside;
    } t_in;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_out;

endpackage
`default_nettype wire

/* src/height_texture_blend_shade_core.sv */
// Height-band texture blend with shading, one terrain pixel per beat.
// Input channel: i_valid / o_stall carry one t_in beat (height, four texels,
// neighbour height and inside flag). A beat is taken when i_valid is high
// and o_stall is low.
// Output channel: o_valid / i_stall carry one t_out beat (red, green, blue).
// Throughput: one pixel per cycle when nothing stalls and no recompute runs.
// Pipeline: nine register stages.
// The stages are: band weights, weight multiply, color sum, four carry
// stages, shade select, output scale; the slope divider (two quotient bits
// a stage) runs alongside in stages one to six.
// Stall: i_stall freezes the full stages next to the output; bubbles ahead
// of them still fill, and o_stall rises when stage zero cannot move.
// Nothing is dropped. Reset: registers take their reset values, the
// pipeline empties, and o_stall stays high while the band and height
// reciprocals are worked out one bit a cycle. Every register write through
// the APB port starts the same recompute. pready is always high.
`default_nettype none
module height_texture_blend_shade_core #(
    parameter int MAX_TEXTURES = htbs_pkg::MAX_TEXTURES_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire htbs_pkg::t_in                i_data,
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output htbs_pkg::t_out                    o_data,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [htbs_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                  pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import htbs_pkg::*;

    localparam int NST = 9;
    localparam int NDIV = 6;

    // configuration
    logic [9:0]  r_max_height;
    logic [2:0]  r_texture_count;
    logic        r_slope_lighting;
    logic [9:0]  r_min_brightness;
    logic [9:0]  r_max_brightness;
    logic [15:0] r_softness;

    logic                 wr_en;
    logic [REG_IDX_W-1:0] reg_idx;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[PADDR_W-1:2];
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_height     <= RST_MAX_HEIGHT;
            r_texture_count  <= RST_TEXTURE_COUNT;
            r_slope_lighting <= RST_SLOPE_LIGHTING;
            r_min_brightness <= RST_MIN_BRIGHTNESS;
            r_max_brightness <= RST_MAX_BRIGHTNESS;
            r_softness       <= RST_SOFTNESS;
        end else if (wr_en) begin
            case (reg_idx)
                REG_MAX_HEIGHT:     r_max_height     <= pwdata[9:0];
                REG_TEXTURE_COUNT:  r_texture_count  <= pwdata[2:0];
                REG_SLOPE_LIGHTING: r_slope_lighting <= pwdata[0];
                REG_MIN_BRIGHTNESS: r_min_brightness <= pwdata[9:0];
                REG_MAX_BRIGHTNESS: r_max_brightness <= pwdata[9:0];
                REG_SOFTNESS:       r_softness       <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_MAX_HEIGHT:     prdata = {22'd0, r_max_height};
            REG_TEXTURE_COUNT:  prdata = {29'd0, r_texture_count};
            REG_SLOPE_LIGHTING: prdata = {31'd0, r_slope_lighting};
            REG_MIN_BRIGHTNESS: prdata = {22'd0, r_min_brightness};
            REG_MAX_BRIGHTNESS: prdata = {22'd0, r_max_brightness};
            REG_SOFTNESS:       prdata = {16'd0, r_softness};
            default:            prdata = 32'd0;
        endcase
    end

    // derived values
    logic [2:0]         n_tex;
    logic [9:0]         band_q;
    logic signed [11:0] n_range;
    logic signed [11:0] r_range;
    logic [25:0]        r_den;
    logic [19:0]        third;

    always_comb begin
        n_tex = (r_texture_count > 3'(MAX_TEXTURES)) ? 3'(MAX_TEXTURES) : r_texture_count;
        third = 20'(r_max_height) * 20'd683;
        case (n_tex)
            3'd1:    band_q = r_max_height;
            3'd2:    band_q = {1'b0, r_max_height[9:1]};
            3'd3:    band_q = {1'b0, third[19:11]};
            3'd4:    band_q = {2'b0, r_max_height[9:2]};
            default: band_q = 10'd0;
        endcase
        n_range = (n_tex == 3'd0) ? 12'sd0 : $signed({2'b0, band_q}) - 12'(BAND_MARGIN);
    end

    always_ff @(posedge i_clk) begin
        r_range <= n_range;
        r_den   <= 26'(r_max_height) * 26'(r_softness);
    end

    // reciprocals ceil(2^31 / d), one bit a cycle
    logic        r_busy;
    logic [4:0]  r_cnt;
    logic [10:0] r_rem_r, r_rem_h;
    logic [30:0] r_q_r, r_q_h;
    logic [31:0] r_m_r, r_m_h;
    logic [9:0]  div_r, div_h;
    logic [10:0] t_r, t_h;
    logic        ge_r, ge_h;

    assign div_r = (r_range > 12'sd0) ? r_range[9:0] : 10'd1;
    assign div_h = (r_max_height != 10'd0) ? r_max_height : 10'd1;
    assign t_r   = {r_rem_r[9:0], 1'b1};
    assign t_h   = {r_rem_h[9:0], 1'b1};
    assign ge_r  = t_r >= {1'b0, div_r};
    assign ge_h  = t_h >= {1'b0, div_h};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || wr_en) begin
            r_busy <= 1'b1;
            r_cnt  <= 5'd0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 5'd1;
            if (r_cnt == 5'd0) begin
                r_rem_r <= 11'd0;
                r_rem_h <= 11'd0;
                r_q_r   <= 31'd0;
                r_q_h   <= 31'd0;
            end else begin
                r_rem_r <= ge_r ? t_r - {1'b0, div_r} : t_r;
                r_rem_h <= ge_h ? t_h - {1'b0, div_h} : t_h;
                r_q_r   <= {r_q_r[29:0], ge_r};
                r_q_h   <= {r_q_h[29:0], ge_h};
                if (r_cnt == 5'd31) begin
                    r_m_r  <= {1'b0, r_q_r[29:0], ge_r} + 32'd1;
                    r_m_h  <= {1'b0, r_q_h[29:0], ge_h} + 32'd1;
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // pipeline handshake
    logic [NST-1:0] r_v;
    logic [NST:0]   en;
    logic           take;

    always_comb begin
        en[NST] = !i_stall;
        for (int s = NST - 1; s >= 0; s--) begin
            en[s] = !r_v[s] || en[s+1];
        end
    end
    assign take    = i_valid && en[0] && !r_busy;
    assign o_stall = !(en[0] && !r_busy);
    assign o_valid = r_v[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) r_v[0] <= take;
            for (int s = 1; s < NST; s++) begin
                if (en[s]) r_v[s] <= r_v[s-1];
            end
        end
    end

    // stage 0: band weights numerators, slope operands
    logic [TEXEL_W-1:0] texel_in [MAX_TEXTURES];
    logic [TEXEL_W-1:0] r0_tex   [MAX_TEXTURES];
    logic [TEXEL_W-1:0] r1_tex   [MAX_TEXTURES];
    logic [9:0]         n0_x     [MAX_TEXTURES];
    logic [9:0]         r0_x     [MAX_TEXTURES];
    logic [MAX_TEXTURES-1:0] n0_act, r0_act;
    logic [8:0]  r0_hs;
    logic        n0_neg, n0_sv, n0_sat;
    logic [7:0]  n0_mag;
    logic signed [8:0] d_nh;

    always_comb begin
        for (int k = 0; k < MAX_TEXTURES; k++) begin
            case (k)
                0:       texel_in[k] = i_data.texel_0;
                1:       texel_in[k] = i_data.texel_1;
                2:       texel_in[k] = i_data.texel_2;
                default: texel_in[k] = i_data.texel_3;
            endcase
        end
    end

    always_comb begin
        logic [12:0]        ctr;
        logic signed [13:0] diff;
        logic [12:0]        ad;
        logic signed [13:0] num;
        for (int k = 0; k < MAX_TEXTURES; k++) begin
            ctr  = 13'(r_range[9:0]) * 13'(k + 1);
            diff = $signed({6'd0, i_data.height}) - $signed({1'b0, ctr});
            ad   = diff[13] ? 13'(-diff) : diff[12:0];
            num  = $signed({4'd0, r_range[9:0]}) - $signed({1'b0, ad});
            n0_act[k] = (r_range > 12'sd0) && (3'(k) < n_tex) && (num > 14'sd0);
            n0_x[k]   = num[9:0];
        end
        d_nh   = $signed({1'b0, i_data.neighbour_height}) - $signed({1'b0, i_data.height});
        n0_neg = d_nh > 9'sd0;
        n0_mag = d_nh[8] ? 8'(-d_nh) : d_nh[7:0];
        n0_sv  = i_data.neighbour_inside && (r_den != 26'd0);
        n0_sat = {14'd0, n0_mag, 16'd0} >= {r_den, 12'd0};
    end

    // slope divider pipeline, index is the pipeline stage
    logic [23:0] r_rem [NDIV+1];
    logic [11:0] r_q   [NDIV+1];
    logic        r_sat [NDIV+1];
    logic        r_neg [NDIV+1];
    logic        r_sv  [NDIV+1];

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            for (int k = 0; k < MAX_TEXTURES; k++) begin
                r0_tex[k] <= texel_in[k];
                r0_x[k]   <= n0_x[k];
            end
            r0_act   <= n0_act;
            r0_hs    <= 9'(i_data.height) + 9'(HEIGHT_OFFSET);
            r_rem[0] <= {n0_mag, 16'd0};
            r_q[0]   <= 12'd0;
            r_sat[0] <= n0_sat;
            r_neg[0] <= n0_neg;
            r_sv[0]  <= n0_sv;
        end
    end

    for (genvar j = 0; j < NDIV; j++) begin : g_div
        localparam int B_HI = 11 - 2 * j;
        logic [37:0] sh_hi, sh_lo;
        logic [23:0] rem_a, rem_b;
        logic        bit_a, bit_b;
        logic [11:0] q_nxt;
        always_comb begin
            sh_hi = 38'(r_den) << B_HI;
            sh_lo = 38'(r_den) << (B_HI - 1);
            bit_a = {14'd0, r_rem[j]} >= sh_hi;
            rem_a = bit_a ? r_rem[j] - sh_hi[23:0] : r_rem[j];
            bit_b = {14'd0, rem_a} >= sh_lo;
            rem_b = bit_b ? rem_a - sh_lo[23:0] : rem_a;
            q_nxt = r_q[j];
            q_nxt[B_HI]   = bit_a;
            q_nxt[B_HI-1] = bit_b;
        end
        always_ff @(posedge i_clk) begin
            if (en[j+1]) begin
                r_rem[j+1] <= rem_b;
                r_q[j+1]   <= q_nxt;
                r_sat[j+1] <= r_sat[j];
                r_neg[j+1] <= r_neg[j];
                r_sv[j+1]  <= r_sv[j];
            end
        end
    end

    // stage 1: weights and height shade
    logic [10:0] r1_w [MAX_TEXTURES];
    logic [MAX_TEXTURES-1:0] r1_act;
    logic [16:0] r1_hq;

    always_ff @(posedge i_clk) begin
        logic [41:0] pw;
        logic [40:0] ph;
        if (en[1]) begin
            for (int k = 0; k < MAX_TEXTURES; k++) begin
                pw = 42'(r0_x[k]) * 42'(r_m_r);
                r1_w[k]   <= pw[31:21];
                r1_act[k] <= r0_act[k] && (pw[31:21] != 11'd0);
                r1_tex[k] <= r0_tex[k];
            end
            ph = 41'(r0_hs) * 41'(r_m_h);
            r1_hq <= ph[39:23];
        end
    end

    // stage 2: color sum; stages 3..6 carry it
    logic [23:0] r_acc [2:NDIV];
    logic [8:0]  r_hsh [2:NDIV];

    always_ff @(posedge i_clk) begin
        logic [7:0]  sum [3];
        logic [18:0] p;
        if (en[2]) begin
            for (int c = 0; c < 3; c++) begin
                sum[c] = 8'd0;
                for (int k = 0; k < MAX_TEXTURES; k++) begin
                    p = 19'(r1_tex[k][16-8*c +: 8]) * 19'(r1_w[k]);
                    if (r1_act[k]) sum[c] = sum[c] + p[17:10];
                end
            end
            r_acc[2] <= {sum[0], sum[1], sum[2]};
            r_hsh[2] <= (r1_hq > 17'(SHADE_ONE)) ? 9'(SHADE_ONE) : r1_hq[8:0];
        end
        for (int s = 3; s <= NDIV; s++) begin
            if (en[s]) begin
                r_acc[s] <= r_acc[s-1];
                r_hsh[s] <= r_hsh[s-1];
            end
        end
    end

    // stage 7: shade
    logic [23:0] r7_acc;
    logic [9:0]  r7_shade;

    always_ff @(posedge i_clk) begin
        logic [12:0]        mag;
        logic signed [14:0] s;
        logic [9:0]         sl;
        if (en[NDIV+1]) begin
            if (r_sat[NDIV]) mag = 13'd4096;
            else mag = 13'(r_q[NDIV]) + 13'(r_neg[NDIV] && (r_rem[NDIV] != 24'd0));
            if (!r_sv[NDIV])       s = 15'sd256;
            else if (r_neg[NDIV])  s = 15'sd256 - $signed({2'b0, mag});
            else                   s = 15'sd256 + $signed({2'b0, mag});
            if (s < $signed({5'd0, r_min_brightness}))      sl = r_min_brightness;
            else if (s > $signed({5'd0, r_max_brightness})) sl = r_max_brightness;
            else                                           sl = s[9:0];
            r7_shade <= r_slope_lighting ? sl : {1'b0, r_hsh[NDIV]};
            r7_acc   <= r_acc[NDIV];
        end
    end

    // stage 8: scale and saturate
    t_out r8_out;
    always_ff @(posedge i_clk) begin
        logic [17:0] v [3];
        logic [7:0]  ch [3];
        if (en[NST-1]) begin
            for (int c = 0; c < 3; c++) begin
                v[c]  = 18'(r7_acc[16-8*c +: 8]) * 18'(r7_shade);
                ch[c] = (v[c][17:8] > 10'(CHAN_MAX)) ? 8'(CHAN_MAX) : v[c][15:8];
            end
            r8_out.red   <= ch[0];
            r8_out.green <= ch[1];
            r8_out.blue  <= ch[2];
        end
    end
    assign o_data = r8_out;

endmodule
`default_nettype wire

/* src/htbs_checker.sv */
`default_nettype none
module htbs_checker (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           o_stall,
    input wire logic           o_valid,
    input wire logic           i_stall,
    input wire htbs_pkg::t_out o_data,
    input wire logic           psel,
    input wire logic           penable,
    input wire logic           pwrite
);
    import htbs_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("output beat changed under stall");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    a_rst_busy: assert property (@(posedge i_clk)
        !i_rst_n |=> o_stall)
        else $error("input taken before reciprocals ready");

    a_cfg_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable && pwrite |=> o_stall)
        else $error("input taken during recompute after register write");

endmodule

bind height_texture_blend_shade_core htbs_checker u_htbs_checker (.*);
`default_nettype wire

/* test/tb.sv */
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import htbs_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    t_in i_data = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    t_out o_data;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    height_texture_blend_shade_core u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_data(i_data), .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    int unsigned cfg_max_height, cfg_tex_count, cfg_slope, cfg_min_br, cfg_max_br, cfg_soft;
    t_out pixel_q[$];
    int errors = 0;
    int idle_cycles = 0;
    bit long_hold = 1'b0;
    bit rand_stall = 1'b0;

    localparam int WATCHDOG = 20000;

    function automatic int floor_div(longint a, longint b);
        longint q;
        q = a / b;
        if ((a % b) != 0 && a < 0) q -= 1;
        return int'(q);
    endfunction

    function automatic t_out shade_pixel(t_in px);
        int unsigned acc[3];
        int unsigned n, w, t, v, shade;
        int range, centre, offs, num;
        longint s, den;
        logic [23:0] tx;
        t_out r;
        acc = '{0, 0, 0};
        n = cfg_tex_count > MAX_TEXTURES_DEF ? MAX_TEXTURES_DEF : cfg_tex_count;
        if (n > 0) begin
            range = int'(cfg_max_height / n) - 5;
            if (range > 0) begin
                for (int k = 0; k < n; k++) begin
                    centre = (k + 1) * range;
                    offs = int'(px.height) - centre;
                    if (offs < 0) offs = -offs;
                    num = range - offs;
                    if (num <= 0) continue;
                    w = (num * 1024) / range;
                    if (w == 0) continue;
                    case (k)
                        0: tx = px.texel_0;
                        1: tx = px.texel_1;
                        2: tx = px.texel_2;
                        default: tx = px.texel_3;
                    endcase
                    for (int c = 0; c < 3; c++) begin
                        t = (tx >> (16 - 8 * c)) & 8'hFF;
                        acc[c] = (acc[c] + ((t * w) >> 10)) & 8'hFF;
                    end
                end
            end
        end
        if (cfg_slope != 0) begin
            s = 256;
            den = longint'(cfg_max_height) * longint'(cfg_soft);
            if (px.neighbour_inside && den != 0)
                s = 256 + floor_div(-(longint'(px.neighbour_height) - longint'(px.height))
                    * 65536, den);
            if (s < longint'(cfg_min_br)) s = cfg_min_br;
            else if (s > longint'(cfg_max_br)) s = cfg_max_br;
            shade = int'(s);
        end else if (cfg_max_height == 0) begin
            shade = 256;
        end else begin
            shade = ((px.height + 50) * 256) / cfg_max_height;
            if (shade > 256) shade = 256;
        end
        for (int c = 0; c < 3; c++) begin
            v = (acc[c] * shade) >> 8;
            if (v > 255) v = 255;
            case (c)
                0: r.red = v[7:0];
                1: r.green = v[7:0];
                default: r.blue = v[7:0];
            endcase
        end
        return r;
    endfunction

    task automatic report(string what, int unsigned got, int unsigned want);
        $display("mismatch %s: got %0d want %0d", what, got, want);
        errors++;
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pixel_q.size() == 0) begin
                report("unexpected beat", o_data, 0);
            end else begin
                want = pixel_q.pop_front();
                if (o_data.red !== want.red) report("red", o_data.red, want.red);
                if (o_data.green !== want.green) report("green", o_data.green, want.green);
                if (o_data.blue !== want.blue) report("blue", o_data.blue, want.blue);
            end
        end
    end

    // receiver stall
    always @(posedge i_clk) begin
        if (long_hold) i_stall <= 1'b1;
        else if (rand_stall) i_stall <= ($urandom_range(0, 99) < 30);
        else i_stall <= 1'b0;
    end

    task automatic hold_receiver();
        long_hold = 1'b1;
        repeat (300) @(posedge i_clk);
        long_hold = 1'b0;
    endtask

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || psel) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return;
        if (r < 95) repeat ($urandom_range(1, 3)) @(posedge i_clk);
        else repeat ($urandom_range(10, 40)) @(posedge i_clk);
    endtask

    task automatic send_pixel(t_in px, bit gaps);
        i_valid <= 1'b1;
        i_data <= px;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pixel_q.push_back(shade_pixel(px));
        if (gaps && $urandom_range(0, 1)) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
            gap();
        end
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pixel_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [REG_IDX_W-1:0] idx, int unsigned val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PADDR_W'(idx) << 2;
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_MAX_HEIGHT: cfg_max_height = val & 10'h3FF;
            REG_TEXTURE_COUNT: cfg_tex_count = val & 3'h7;
            REG_SLOPE_LIGHTING: cfg_slope = val & 1;
            REG_MIN_BRIGHTNESS: cfg_min_br = val & 10'h3FF;
            REG_MAX_BRIGHTNESS: cfg_max_br = val & 10'h3FF;
            default: cfg_soft = val & 16'hFFFF;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_all(int unsigned mh, int unsigned tc, int unsigned sl,
                           int unsigned mn, int unsigned mx, int unsigned sf);
        write_reg(REG_MAX_HEIGHT, mh);
        write_reg(REG_TEXTURE_COUNT, tc);
        write_reg(REG_SLOPE_LIGHTING, sl);
        write_reg(REG_MIN_BRIGHTNESS, mn);
        write_reg(REG_MAX_BRIGHTNESS, mx);
        write_reg(REG_SOFTNESS, sf);
    endtask

    function automatic t_in rand_pixel();
        t_in px;
        px.height = $urandom;
        px.texel_0 = $urandom;
        px.texel_1 = $urandom;
        px.texel_2 = $urandom;
        px.texel_3 = $urandom;
        px.neighbour_height = ($urandom_range(0, 1)) ? $urandom :
            8'(int'(px.height) + $urandom_range(0, 20) - 10);
        px.neighbour_inside = ($urandom_range(0, 9) != 0);
        return px;
    endfunction

    function automatic t_in make_pixel(logic [7:0] h, logic [23:0] tx, logic [7:0] hn, bit ins);
        t_in px;
        px = '{h, tx, tx, tx, tx, hn, ins};
        return px;
    endfunction

    task automatic test_directed();
        send_pixel(make_pixel(8'd0, 24'hFFFFFF, 8'd0, 1'b1), 0);
        send_pixel(make_pixel(8'd255, 24'hFFFFFF, 8'd0, 1'b1), 0);
        send_pixel(make_pixel(8'd0, 24'hFFFFFF, 8'd255, 1'b1), 0);
        send_pixel(make_pixel(8'd50, 24'h000000, 8'd255, 1'b0), 0);
        send_pixel(make_pixel(8'd100, 24'hA5C35A, 8'd90, 1'b1), 0);
        send_pixel(make_pixel(8'd150, 24'h5A3CA5, 8'd170, 1'b1), 0);
        drain();
        set_all(1023, 0, 0, 0, 1023, 1);           // no textures
        send_pixel(make_pixel(8'd200, 24'hFFFFFF, 8'd0, 1'b1), 0);
        drain();
        set_all(1023, 7, 0, 0, 1023, 1);           // count above max, height shade
        for (int h = 0; h < 256; h += 51)
            send_pixel(make_pixel(h[7:0], 24'hFFFFFF, 8'd0, 1'b1), 0);
        drain();
        set_all(20, 4, 1, 0, 1023, 1);             // narrow band
        send_pixel(make_pixel(8'd3, 24'hFFFFFF, 8'd0, 1'b1), 0);
        drain();
        set_all(0, 1, 0, 0, 0, 0);                 // zero divisors
        send_pixel(make_pixel(8'd10, 24'hFFFFFF, 8'd0, 1'b1), 0);
        drain();
        write_reg(REG_SLOPE_LIGHTING, 1);
        write_reg(REG_MAX_BRIGHTNESS, 1023);
        send_pixel(make_pixel(8'd10, 24'hFFFFFF, 8'd0, 1'b1), 0);
        drain();
        set_all(300, 2, 1, 600, 100, 65535);      // crossed limits
        send_pixel(make_pixel(8'd140, 24'hFFFFFF, 8'd0, 1'b1), 0);
        send_pixel(make_pixel(8'd140, 24'hFFFFFF, 8'd255, 1'b1), 0);
        drain();
    endtask

    task automatic test_random();
        for (int p = 0; p < 6; p++) begin
            if (p == 0) set_all(1, 1, 0, 0, 0, 1);
            else if (p == 1) set_all(1023, 4, 1, 1023, 1023, 65535);
            else set_all($urandom_range(1, 1023), $urandom_range(0, 7), $urandom_range(0, 1),
                         $urandom_range(0, 400), $urandom_range(100, 1023),
                         $urandom_range(1, 65535));
            rand_stall = 1'b1;
            for (int i = 0; i < 90; i++) send_pixel(rand_pixel(), 1);
            drain();
        end
        rand_stall = 1'b0;
    endtask

    task automatic test_backpressure();
        set_all(255, 4, 1, 128, 256, 256);
        fork
            hold_receiver();
        join_none
        @(posedge i_clk);
        for (int i = 0; i < 40; i++) send_pixel(rand_pixel(), 0);
        drain();
    endtask

    initial begin
        cfg_max_height = RST_MAX_HEIGHT;
        cfg_tex_count = RST_TEXTURE_COUNT;
        cfg_slope = RST_SLOPE_LIGHTING;
        cfg_min_br = RST_MIN_BRIGHTNESS;
        cfg_max_br = RST_MAX_BRIGHTNESS;
        cfg_soft = RST_SOFTNESS;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random();
        test_backpressure();
        if (errors == 0 && pixel_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
